[src/e2r_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and helper functions for the Euler angle to
// rotation matrix converter.
// ----------------------------------------------------------------------------
package e2r_pkg;

    // Field widths
    localparam int ANGLE_W        = 16;
    localparam int ELEM_W         = 16;
    localparam int ELEM_FRAC_BITS = 14;

    // Angle units: degrees times 64
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int EIGHTH_TURN  = 2880;

    // x = r * X_BASE + floor((r * X_FRAC_NUM + X_FRAC_RND) / 5760)
    // X_BASE and the fraction split pi * 2^30 / 11520 exactly.
    localparam int unsigned X_BASE     = 292817;
    localparam int unsigned X_FRAC_NUM = 3793;
    localparam int unsigned X_FRAC_RND = 2880;
    // Reciprocal of 5760, exact for numerators below 2^24
    localparam int unsigned X_RECIP    = 11930465;
    localparam int          X_RECIP_SH = 36;

    // Horner divisors for sine and cosine
    localparam int SIN_STEPS = 4;
    localparam int COS_STEPS = 5;
    localparam int unsigned SIN_K [SIN_STEPS] = '{72, 42, 20, 6};
    localparam int unsigned COS_K [COS_STEPS] = '{90, 56, 30, 12, 2};

    // Pipeline depths
    localparam int LANE_LAT  = 18;
    localparam int MERGE_LAT = 5;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef logic signed [31:0] q30_t;
    typedef q30_t [2:0][2:0] mat_t;

    // Sine and cosine of one angle, Q30
    typedef struct packed {
        q30_t s;
        q30_t c;
    } sc_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic {
        ORDER_ZXZ = 1'b0,
        ORDER_ZYX = 1'b1
    } order_t;

    // Elementary rotation about one axis
    function automatic mat_t rot_mat(input axis_t axis, input sc_t sc);
        mat_t m;
        m = '0;
        m[0][0] = q30_t'(ONE_Q30);
        m[1][1] = q30_t'(ONE_Q30);
        m[2][2] = q30_t'(ONE_Q30);
        case (axis)
            AXIS_X:
            begin
                m[1][1] = sc.c;
                m[1][2] = -sc.s;
                m[2][1] = sc.s;
                m[2][2] = sc.c;
            end
            AXIS_Y:
            begin
                m[0][0] = sc.c;
                m[0][2] = sc.s;
                m[2][0] = -sc.s;
                m[2][2] = sc.c;
            end
            AXIS_Z:
            begin
                m[0][0] = sc.c;
                m[0][1] = -sc.s;
                m[1][0] = sc.s;
                m[1][1] = sc.c;
            end
            default:
            begin
                m[0][0] = q30_t'(ONE_Q30);
            end
        endcase
        return m;
    endfunction

    // Q60 sum back to Q30, round half up
    function automatic q30_t rnd_q30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd536870912;
        return q30_t'(t >>> 30);
    endfunction

endpackage

[src/e2r_pose_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pose_if
// Input channel: three Euler angles, degrees times 64.
// ----------------------------------------------------------------------------
interface e2r_pose_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [e2r_pkg::ANGLE_W-1:0]   angle_first;
    logic signed [e2r_pkg::ANGLE_W-1:0]   angle_second;
    logic signed [e2r_pkg::ANGLE_W-1:0]   angle_third;

    modport source (output valid, angle_first, angle_second, angle_third, input ready);
    modport sink   (input valid, angle_first, angle_second, angle_third, output ready);
endinterface

[src/e2r_matrix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_matrix_if
// Output channel: nine rotation matrix elements, row-major.
// ----------------------------------------------------------------------------
interface e2r_matrix_if;
    logic                               valid;
    logic                               ready;
    logic signed [e2r_pkg::ELEM_W-1:0]  m00;
    logic signed [e2r_pkg::ELEM_W-1:0]  m01;
    logic signed [e2r_pkg::ELEM_W-1:0]  m02;
    logic signed [e2r_pkg::ELEM_W-1:0]  m10;
    logic signed [e2r_pkg::ELEM_W-1:0]  m11;
    logic signed [e2r_pkg::ELEM_W-1:0]  m12;
    logic signed [e2r_pkg::ELEM_W-1:0]  m20;
    logic signed [e2r_pkg::ELEM_W-1:0]  m21;
    logic signed [e2r_pkg::ELEM_W-1:0]  m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

[src/euler_to_rotation_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Three Euler angles to a 3x3 rotation matrix, ZXZ or ZYX order.
//
//   channel        dir  handshake      payload
//   pose           in   valid/ready    angle_first/second/third, deg*64
//   matrix         out  valid/ready    m00..m22, Q1.14
//   cfg_wr_*       in   write enable   rotation_order (1 bit)
//
// Angles pass through the sine/cosine lanes, then the matrix merge.
// One pose per cycle sustained while the matrix output is not stalled;
// the trig lanes and matrix stages are fully pipelined.
// Reset clears the valid pipeline and sets ZXZ order.
// A stalled matrix transfer freezes the whole pipeline; pose.ready follows.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    e2r_pose_if.sink             pose,
    e2r_matrix_if.source         matrix
);
    import e2r_pkg::*;

    // Order register
    order_t order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= ORDER_ZXZ;
        else if (cfg_wr_en)
            order_reg <= order_t'(cfg_wr_data);
    end

    // Pipeline advance and valid tracking
    logic                 adv;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    assign adv      = !vld_reg[TOTAL_LAT-1] || matrix.ready;
    assign vld_next = {vld_reg[TOTAL_LAT-2:0], pose.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    assign pose.ready   = adv;
    assign matrix.valid = vld_reg[TOTAL_LAT-1];

    // Three trig lanes
    sc_t sc_first;
    sc_t sc_second;
    sc_t sc_third;

    e2r_sincos_lane u_lane_first (
        .clk    (clk),
        .en     (adv),
        .angle  (pose.angle_first),
        .result (sc_first)
    );

    e2r_sincos_lane u_lane_second (
        .clk    (clk),
        .en     (adv),
        .angle  (pose.angle_second),
        .result (sc_second)
    );

    e2r_sincos_lane u_lane_third (
        .clk    (clk),
        .en     (adv),
        .angle  (pose.angle_third),
        .result (sc_third)
    );

    // Matrix composition
    logic [8:0][ELEM_W-1:0] elems;

    e2r_merge u_merge (
        .clk         (clk),
        .en          (adv),
        .order       (order_reg),
        .lane_first  (sc_first),
        .lane_second (sc_second),
        .lane_third  (sc_third),
        .elems       (elems)
    );

    assign matrix.m00 = elems[0];
    assign matrix.m01 = elems[1];
    assign matrix.m02 = elems[2];
    assign matrix.m10 = elems[3];
    assign matrix.m11 = elems[4];
    assign matrix.m12 = elems[5];
    assign matrix.m20 = elems[6];
    assign matrix.m21 = elems[7];
    assign matrix.m22 = elems[8];

`ifndef SYNTH
    // Input is held off only by a stalled result
    a_ready_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !pose.ready |-> (matrix.valid && !matrix.ready))
        else $error("pose.ready low without output stall");

    // An accepted pose enters the valid pipeline
    a_accept_tracked : assert property (@(posedge clk) disable iff (!rst_n)
        (pose.valid && pose.ready) |=> vld_reg[0])
        else $error("accepted pose not tracked");

    // A stall freezes every valid stage
    a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid pipeline moved during stall");
`endif

endmodule

[src/e2r_sincos_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_sincos_lane
// Pipelined sine/cosine of one angle: range reduction, conversion to
// radians, Horner polynomial steps, octant and quadrant mapping.
// Advances only while en is high.
// ----------------------------------------------------------------------------
module e2r_sincos_lane (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [e2r_pkg::ANGLE_W-1:0]  angle,
    output e2r_pkg::sc_t                        result
);
    import e2r_pkg::*;

    typedef struct packed {
        logic [1:0] q;
        logic       swap;
    } meta_t;

    // Stage 1: reduce to [0, 360), split quadrant and octant
    logic signed [17:0] u_s;
    logic [16:0]        u;
    logic [16:0]        t_red;
    logic [1:0]         q_next;
    logic [16:0]        r_full;
    logic               swap_next;
    logic [11:0]        rp_next;
    logic [11:0]        rp_reg;
    meta_t              meta_reg [1:LANE_LAT-1];

    assign u_s = {{2{angle[ANGLE_W-1]}}, angle} + 18'sd46080;
    assign u   = u_s[16:0];

    always_comb
    begin
        if (u >= 17'(3 * FULL_TURN))
            t_red = u - 17'(3 * FULL_TURN);
        else if (u >= 17'(2 * FULL_TURN))
            t_red = u - 17'(2 * FULL_TURN);
        else if (u >= 17'(FULL_TURN))
            t_red = u - 17'(FULL_TURN);
        else
            t_red = u;

        if (t_red >= 17'(3 * QUARTER_TURN))
        begin
            q_next = 2'd3;
            r_full = t_red - 17'(3 * QUARTER_TURN);
        end
        else if (t_red >= 17'(2 * QUARTER_TURN))
        begin
            q_next = 2'd2;
            r_full = t_red - 17'(2 * QUARTER_TURN);
        end
        else if (t_red >= 17'(QUARTER_TURN))
        begin
            q_next = 2'd1;
            r_full = t_red - 17'(QUARTER_TURN);
        end
        else
        begin
            q_next = 2'd0;
            r_full = t_red;
        end

        swap_next = (r_full > 17'(EIGHTH_TURN));
        rp_next   = swap_next ? 12'(17'(QUARTER_TURN) - r_full) : r_full[11:0];
    end

    // Stages 2-4: x = r * pi / 11520 in Q30
    logic [23:0] n_reg;
    logic [30:0] base_reg;
    logic [47:0] nm_reg;
    logic [30:0] base3_reg;
    logic [29:0] x_reg [4:LANE_LAT-4];

    // Stages 5-6: x squared
    logic [59:0] xx_reg;
    logic [29:0] x2_reg [6:LANE_LAT-4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg      <= rp_next;
            meta_reg[1] <= '{q: q_next, swap: swap_next};
            for (int i = 2; i < LANE_LAT; i++)
                meta_reg[i] <= meta_reg[i-1];

            n_reg     <= 24'(rp_reg) * 24'(X_FRAC_NUM) + 24'(X_FRAC_RND);
            base_reg  <= 31'(rp_reg) * 31'(X_BASE);
            nm_reg    <= 48'(n_reg) * 48'(X_RECIP);
            base3_reg <= base_reg;
            x_reg[4]  <= 30'(base3_reg) + 30'(nm_reg[47:X_RECIP_SH]);
            for (int i = 5; i <= LANE_LAT - 4; i++)
                x_reg[i] <= x_reg[i-1];

            xx_reg    <= 60'(x_reg[4]) * 60'(x_reg[4]);
            x2_reg[6] <= 30'((xx_reg + 60'(1 << 29)) >> 30);
            for (int i = 7; i <= LANE_LAT - 4; i++)
                x2_reg[i] <= x2_reg[i-1];
        end
    end

    // Sine Horner chain, two stages per step
    logic [60:0] sprod_reg [SIN_STEPS];
    logic [62:0] sdiv_reg  [SIN_STEPS];
    logic [30:0] st_in     [SIN_STEPS];
    logic [30:0] sq        [SIN_STEPS];

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        localparam int unsigned K  = SIN_K[i];
        localparam int          SH = 31 + $clog2(K);
        localparam logic [63:0] M64 = ((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K);
        localparam logic [31:0] M  = M64[31:0];
        logic [30:0] v;

        if (i == 0)
        begin : g_first
            assign st_in[i] = ONE_Q30;
        end
        else
        begin : g_next
            assign st_in[i] = ONE_Q30 - sq[i-1];
        end

        assign v     = 31'((sprod_reg[i] + 61'(1 << 29)) >> 30);
        assign sq[i] = 31'(sdiv_reg[i] >> SH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sprod_reg[i] <= 61'(x2_reg[6 + 2 * i]) * 61'(st_in[i]);
                sdiv_reg[i]  <= 63'(v + 31'(K / 2)) * 63'(M);
            end
        end
    end

    // Cosine Horner chain
    logic [60:0] cprod_reg [COS_STEPS];
    logic [62:0] cdiv_reg  [COS_STEPS];
    logic [30:0] ct_in     [COS_STEPS];
    logic [30:0] cq        [COS_STEPS];

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        localparam int unsigned K  = COS_K[i];
        localparam int          SH = 31 + $clog2(K);
        localparam logic [63:0] M64 = ((64'd1 << SH) + 64'(K) - 64'd1) / 64'(K);
        localparam logic [31:0] M  = M64[31:0];
        logic [30:0] v;

        if (i == 0)
        begin : g_first
            assign ct_in[i] = ONE_Q30;
        end
        else
        begin : g_next
            assign ct_in[i] = ONE_Q30 - cq[i-1];
        end

        assign v     = 31'((cprod_reg[i] + 61'(1 << 29)) >> 30);
        assign cq[i] = 31'(cdiv_reg[i] >> SH);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cprod_reg[i] <= 61'(x2_reg[6 + 2 * i]) * 61'(ct_in[i]);
                cdiv_reg[i]  <= 63'(v + 31'(K / 2)) * 63'(M);
            end
        end
    end

    // Stages 15-17: sine times x, cosine finish
    logic [60:0] sfin_reg;
    logic [30:0] s16_reg;
    logic [30:0] s17_reg;
    logic [30:0] c17_reg;
    logic [30:0] ss;
    logic [30:0] cc;
    q30_t        sp;
    q30_t        cp;
    sc_t         res_next;
    sc_t         res_reg;

    // Stage 18: undo octant fold, then quadrant mapping
    always_comb
    begin
        ss = meta_reg[LANE_LAT-1].swap ? c17_reg : s17_reg;
        cc = meta_reg[LANE_LAT-1].swap ? s17_reg : c17_reg;
        sp = q30_t'(ss);
        cp = q30_t'(cc);
        case (meta_reg[LANE_LAT-1].q)
            2'd1:    res_next = '{s: cp,  c: -sp};
            2'd2:    res_next = '{s: -sp, c: -cp};
            2'd3:    res_next = '{s: -cp, c: sp};
            default: res_next = '{s: sp,  c: cp};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sfin_reg <= 61'(x_reg[LANE_LAT-4]) * 61'(ONE_Q30 - sq[SIN_STEPS-1]);
            s16_reg  <= 31'((sfin_reg + 61'(1 << 29)) >> 30);
            s17_reg  <= s16_reg;
            c17_reg  <= ONE_Q30 - cq[COS_STEPS-1];
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

[src/e2r_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_merge
// Builds the three elementary rotations from the lane results, forms the
// two matrix products and rounds/saturates the elements.
// ----------------------------------------------------------------------------
module e2r_merge (
    input  logic                                    clk,
    input  logic                                    en,
    input  e2r_pkg::order_t                         order,
    input  e2r_pkg::sc_t                            lane_first,
    input  e2r_pkg::sc_t                            lane_second,
    input  e2r_pkg::sc_t                            lane_third,
    output logic [8:0][e2r_pkg::ELEM_W-1:0]         elems
);
    import e2r_pkg::*;

    localparam int                 OUT_SHIFT = 30 - ELEM_FRAC_BITS;
    localparam logic signed [63:0] OUT_HALF  = (64'sd1 <<< OUT_SHIFT) >>> 1;
    localparam logic signed [63:0] OUT_LIM   = 64'sd1 <<< ELEM_FRAC_BITS;

    // Pick axes and angles for the selected order
    mat_t m1;
    mat_t m2;
    mat_t m3;

    always_comb
    begin
        case (order)
            ORDER_ZYX:
            begin
                m1 = rot_mat(AXIS_Z, lane_third);
                m2 = rot_mat(AXIS_Y, lane_second);
                m3 = rot_mat(AXIS_X, lane_first);
            end
            default:
            begin
                m1 = rot_mat(AXIS_Z, lane_first);
                m2 = rot_mat(AXIS_X, lane_second);
                m3 = rot_mat(AXIS_Z, lane_third);
            end
        endcase
    end

    logic signed [63:0] pr1_reg [3][3][3];
    logic signed [63:0] pr2_reg [3][3][3];
    mat_t               m3a_reg;
    mat_t               m3b_reg;
    mat_t               p_reg;
    mat_t               r_reg;
    logic [8:0][ELEM_W-1:0] out_next;
    logic [8:0][ELEM_W-1:0] out_reg;

    // Element rounding to the output format, then saturation
    always_comb
    begin
        logic signed [63:0] v;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                v = 64'(r_reg[i][j]);
                if (OUT_SHIFT > 0)
                    v = (v + OUT_HALF) >>> OUT_SHIFT;
                if (v > OUT_LIM)
                    v = OUT_LIM;
                if (v < -OUT_LIM)
                    v = -OUT_LIM;
                out_next[i * 3 + j] = v[ELEM_W-1:0];
            end
        end
    end

    // Product stages and Q30 rounding stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                    begin
                        pr1_reg[i][j][k] <= 64'(m1[i][k]) * 64'(m2[k][j]);
                        pr2_reg[i][j][k] <= 64'(p_reg[i][k]) * 64'(m3b_reg[k][j]);
                    end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    p_reg[i][j] <= rnd_q30(pr1_reg[i][j][0] + pr1_reg[i][j][1]
                                           + pr1_reg[i][j][2]);
                    r_reg[i][j] <= rnd_q30(pr2_reg[i][j][0] + pr2_reg[i][j][1]
                                           + pr2_reg[i][j][2]);
                end
            m3a_reg <= m3;
            m3b_reg <= m3a_reg;
            out_reg <= out_next;
        end
    end

    assign elems = out_reg;

endmodule
